// ===== rtl/life_grid_step_with_undo_top_assert.svh =====
// Assertion macros for the RTL; clock i_clk, synchronous reset i_rst_n.
`ifndef LIFE_GRID_STEP_WITH_UNDO_TOP_ASSERT_SVH
`define LIFE_GRID_STEP_WITH_UNDO_TOP_ASSERT_SVH

// Same-cycle implication.
`define LGSU_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define LGSU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/lgsu_pkg.sv =====
package lgsu_pkg;

    localparam int GRID_ROWS     = 64;
    localparam int GRID_COLS     = 64;
    localparam int HISTORY_DEPTH = 4;

    localparam int WORD_W   = 64;
    localparam int ROW_W    = $clog2(GRID_ROWS);
    localparam int COL_W    = 6;
    localparam int PTR_W    = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int SNAP_DEPTH = HISTORY_DEPTH * GRID_ROWS;
    localparam int SNAP_AW  = $clog2(SNAP_DEPTH);
    localparam int CNT_W    = $clog2(GRID_ROWS + 2);

    typedef logic [WORD_W-1:0] t_word;

    localparam t_word COL_MASK = {WORD_W{1'b1}} >> (WORD_W - GRID_COLS);

    localparam logic [1:0] OP_TOGGLE = 2'd0;
    localparam logic [1:0] OP_STEP   = 2'd1;
    localparam logic [1:0] OP_UNDO   = 2'd2;
    localparam logic [1:0] OP_READ   = 2'd3;

    localparam logic STAT_OK      = 1'b0;
    localparam logic STAT_NO_SNAP = 1'b1;

endpackage

// ===== rtl/life_grid_step_with_undo_top.sv =====
// Game of Life grid (B3/S23, dead borders) with a snapshot ring for undo.
// Input channel: i_in_valid / o_in_stall with i_opcode, i_row_index, i_col_index.
// A command transfers at a clock edge with i_in_valid high and o_in_stall low.
// Output channel: o_out_valid / i_out_stall with o_row_bits, o_status; every
// command yields exactly one result, row_bits being zero except for read row.
// Commands are processed one at a time; the input stalls from transfer until the
// command has finished and its result has gone into the output register. The
// grid sits in one single-port-read memory, so step and undo sweep it one row
// per cycle; step writes the old row into the snapshot memory in the same pass.
// The result is loaded into an output register from the final state once that
// register is free. While the receiver stalls, the result holds there and the next
// command may still be taken and worked on; it waits at its end until the
// register frees up.
// Synchronous reset clears the grid (per-row valid bits), the snapshot marks,
// the ring pointer and the output valid flag; no clearing sweep is needed.
module life_grid_step_with_undo_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_opcode,
    input  logic [5:0]  i_row_index,
    input  logic [5:0]  i_col_index,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [63:0] o_row_bits,
    output logic        o_status
);

    `include "life_grid_step_with_undo_top_assert.svh"

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_TOG  = 3'd1;
    localparam logic [2:0] ST_RD   = 3'd2;
    localparam logic [2:0] ST_STEP = 3'd3;
    localparam logic [2:0] ST_UNDO = 3'd4;
    localparam logic [2:0] ST_FIN  = 3'd5;

    localparam int ROW_W   = lgsu_pkg::ROW_W;
    localparam int PTR_W   = lgsu_pkg::PTR_W;
    localparam int CNT_W   = lgsu_pkg::CNT_W;
    localparam int SNAP_AW = lgsu_pkg::SNAP_AW;

    // memories
    lgsu_pkg::t_word mem_grid [lgsu_pkg::GRID_ROWS];
    lgsu_pkg::t_word mem_snap [lgsu_pkg::SNAP_DEPTH];

    logic [2:0]                   r_state, n_state;
    logic [CNT_W-1:0]             r_cnt, n_cnt;
    logic [PTR_W-1:0]             r_ptr, n_ptr;
    logic [PTR_W-1:0]             r_slot, n_slot;
    logic [lgsu_pkg::HISTORY_DEPTH-1:0] r_snapv, n_snapv;
    logic [lgsu_pkg::GRID_ROWS-1:0]     r_rowv;
    logic                         r_res_status, n_res_status;
    lgsu_pkg::t_word              r_res_bits, n_res_bits;
    logic [ROW_W-1:0]             r_row;
    logic [lgsu_pkg::COL_W-1:0]   r_col;
    logic                         r_hit;
    lgsu_pkg::t_word              r_win_a, r_win_h;
    lgsu_pkg::t_word              r_grid_q;
    logic                         r_grid_ok;
    lgsu_pkg::t_word              r_snap_q;
    logic                         r_out_valid;
    lgsu_pkg::t_word              r_out_bits;
    logic                         r_out_status;

    logic                         in_acc;
    logic                         out_free;
    logic                         out_load;
    logic [PTR_W-1:0]             undo_slot;
    logic [PTR_W-1:0]             step_next;
    logic [ROW_W-1:0]             rd_addr;
    lgsu_pkg::t_word              cur_row;
    lgsu_pkg::t_word              below;
    lgsu_pkg::t_word              rule_next;
    logic                         grid_we;
    logic [ROW_W-1:0]             grid_wa;
    lgsu_pkg::t_word              grid_wd;
    logic                         snap_we;
    logic [SNAP_AW-1:0]           slot_base;
    logic [SNAP_AW-1:0]           snap_wa;
    logic [SNAP_AW-1:0]           snap_ra;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign out_load    = (r_state == ST_FIN) && out_free;
    assign o_out_valid = r_out_valid;
    assign o_row_bits  = r_out_bits;
    assign o_status    = r_out_status;

    assign undo_slot = (r_ptr == '0) ? PTR_W'(lgsu_pkg::HISTORY_DEPTH - 1) : r_ptr - 1'b1;
    assign step_next = (r_ptr == PTR_W'(lgsu_pkg::HISTORY_DEPTH - 1)) ? '0 : r_ptr + 1'b1;

    // Rows never written since reset read as dead.
    assign cur_row = r_grid_ok ? r_grid_q : '0;

    // During a step, the row arriving from memory is the lower edge of the window.
    assign below = ((r_cnt >= CNT_W'(1)) && (r_cnt <= CNT_W'(lgsu_pkg::GRID_ROWS)))
                 ? cur_row : '0;

    assign rd_addr   = (r_state == ST_STEP) ? ROW_W'(r_cnt) : ROW_W'(i_row_index);
    assign slot_base = SNAP_AW'(r_slot) * SNAP_AW'(lgsu_pkg::GRID_ROWS);
    assign snap_ra   = slot_base + SNAP_AW'(r_cnt);
    assign snap_wa   = slot_base + SNAP_AW'(r_cnt - CNT_W'(1));

    lgsu_row_rule u_rule (
        .i_above (r_win_a),
        .i_here  (r_win_h),
        .i_below (below),
        .o_next  (rule_next)
    );

    // write port selection
    always_comb begin
        grid_we = 1'b0;
        grid_wa = r_row;
        grid_wd = cur_row ^ (lgsu_pkg::t_word'(1) << r_col);
        snap_we = 1'b0;
        unique case (r_state)
            ST_TOG: begin
                grid_we = r_hit;
            end
            ST_STEP: begin
                // new row trails the read row by two
                grid_we = (r_cnt >= CNT_W'(2));
                grid_wa = ROW_W'(r_cnt - CNT_W'(2));
                grid_wd = rule_next;
                snap_we = (r_cnt >= CNT_W'(1)) && (r_cnt <= CNT_W'(lgsu_pkg::GRID_ROWS));
            end
            ST_UNDO: begin
                grid_we = (r_cnt >= CNT_W'(1));
                grid_wa = ROW_W'(r_cnt - CNT_W'(1));
                grid_wd = r_snap_q;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_ptr        = r_ptr;
        n_slot       = r_slot;
        n_snapv      = r_snapv;
        n_res_bits   = r_res_bits;
        n_res_status = r_res_status;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_cnt        = '0;
                    n_res_bits   = '0;
                    n_res_status = lgsu_pkg::STAT_OK;
                    unique case (i_opcode)
                        lgsu_pkg::OP_TOGGLE: begin
                            n_state = ST_TOG;
                        end
                        lgsu_pkg::OP_STEP: begin
                            n_slot           = r_ptr;
                            n_ptr            = step_next;
                            n_snapv[r_ptr]   = 1'b1;
                            n_state          = ST_STEP;
                        end
                        lgsu_pkg::OP_UNDO: begin
                            n_slot = undo_slot;
                            n_ptr  = undo_slot;
                            if (r_snapv[undo_slot]) begin
                                n_snapv[undo_slot] = 1'b0;
                                n_state            = ST_UNDO;
                            end else begin
                                n_res_status = lgsu_pkg::STAT_NO_SNAP;
                                n_state      = ST_FIN;
                            end
                        end
                        lgsu_pkg::OP_READ: begin
                            n_state = ST_RD;
                        end
                    endcase
                end
            end
            ST_TOG: begin
                n_state = ST_FIN;
            end
            ST_RD: begin
                n_res_bits = r_hit ? (cur_row & lgsu_pkg::COL_MASK) : '0;
                n_state    = ST_FIN;
            end
            ST_STEP: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(lgsu_pkg::GRID_ROWS + 1)) begin
                    n_state = ST_FIN;
                end
            end
            ST_UNDO: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(lgsu_pkg::GRID_ROWS)) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_ptr       <= '0;
            r_slot      <= '0;
            r_snapv     <= '0;
            r_rowv      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_ptr   <= n_ptr;
            r_slot  <= n_slot;
            r_snapv <= n_snapv;
            if (grid_we) begin
                r_rowv[grid_wa] <= 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res_bits   <= n_res_bits;
        r_res_status <= n_res_status;
        if (in_acc) begin
            r_row   <= ROW_W'(i_row_index);
            r_col   <= i_col_index;
            r_hit   <= (int'(i_row_index) < lgsu_pkg::GRID_ROWS)
                    && ((i_opcode != lgsu_pkg::OP_TOGGLE)
                        || (int'(i_col_index) < lgsu_pkg::GRID_COLS));
            r_win_a <= '0;
            r_win_h <= '0;
        end else if ((r_state == ST_STEP) && (r_cnt >= CNT_W'(1))) begin
            // advance the three-row window
            r_win_a <= r_win_h;
            r_win_h <= below;
        end
        if (out_load) begin
            r_out_bits   <= r_res_bits;
            r_out_status <= r_res_status;
        end
    end

    // grid memory: one read, one write per cycle
    always_ff @(posedge i_clk) begin
        r_grid_q  <= mem_grid[rd_addr];
        r_grid_ok <= r_rowv[rd_addr];
        if (grid_we) begin
            mem_grid[grid_wa] <= grid_wd & lgsu_pkg::COL_MASK;
        end
    end

    // snapshot memory
    always_ff @(posedge i_clk) begin
        r_snap_q <= mem_snap[snap_ra];
        if (snap_we) begin
            mem_snap[snap_wa] <= below;
        end
    end

    `LGSU_ASSERT_NOW(a_no_write_idle, (r_state == ST_IDLE) || (r_state == ST_FIN),
        !grid_we && !snap_we)
    `LGSU_ASSERT_NOW(a_step_write_lags, (r_state == ST_STEP) && grid_we,
        grid_wa != rd_addr)
    `LGSU_ASSERT_NEXT(a_undo_ptr, i_rst_n && in_acc && (i_opcode == lgsu_pkg::OP_UNDO),
        (r_ptr == $past(undo_slot)) && !r_snapv[$past(undo_slot)])
    `LGSU_ASSERT_NEXT(a_step_mark, i_rst_n && in_acc && (i_opcode == lgsu_pkg::OP_STEP),
        r_snapv[$past(r_ptr)] && (r_slot == $past(r_ptr)))

endmodule

// ===== rtl/lgsu_row_rule.sv =====
module lgsu_row_rule (
    input  lgsu_pkg::t_word i_above,
    input  lgsu_pkg::t_word i_here,
    input  lgsu_pkg::t_word i_below,
    output lgsu_pkg::t_word o_next
);

    lgsu_pkg::t_word a;
    lgsu_pkg::t_word h;
    lgsu_pkg::t_word b;

    assign a = i_above & lgsu_pkg::COL_MASK;
    assign h = i_here  & lgsu_pkg::COL_MASK;
    assign b = i_below & lgsu_pkg::COL_MASK;

    // Shifted copies put the left and right neighbors of column c at bit c;
    // zeros shift in at both edges, so the border reads as dead.
    always_comb begin : p_rule
        logic [3:0]      nbr;
        lgsu_pkg::t_word a_l, a_r, h_l, h_r, b_l, b_r, res;
        a_l = a << 1;
        a_r = a >> 1;
        h_l = h << 1;
        h_r = h >> 1;
        b_l = b << 1;
        b_r = b >> 1;
        res = '0;
        for (int c = 0; c < lgsu_pkg::WORD_W; c++) begin
            nbr = 4'(a_l[c]) + 4'(a[c]) + 4'(a_r[c]) + 4'(h_l[c]) + 4'(h_r[c])
                + 4'(b_l[c]) + 4'(b[c]) + 4'(b_r[c]);
            res[c] = (nbr == 4'd3) || ((nbr == 4'd2) && h[c]);
        end
        o_next = res & lgsu_pkg::COL_MASK;
    end

endmodule

// ===== sim/life_grid_step_with_undo_top_test.sv =====
module life_grid_step_with_undo_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 80;
    localparam int RANDOM_ITEMS = 500;
    localparam int HOLD_CYCLES  = 300;
    localparam int IDLE_PCT     = 15;

    typedef struct {
        logic [1:0]                 op;
        logic [lgsu_pkg::ROW_W-1:0] row;
        logic [lgsu_pkg::COL_W-1:0] col;
    } t_cmd;

    typedef struct {
        lgsu_pkg::t_word row_bits;
        logic            status;
    } t_result;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    logic [1:0]        i_opcode    = lgsu_pkg::OP_READ;
    logic [5:0]        i_row_index = '0;
    logic [5:0]        i_col_index = '0;
    logic              i_out_stall = 1'b0;
    logic              o_in_stall;
    logic              o_out_valid;
    logic [63:0]       o_row_bits;
    logic              o_status;

    t_cmd    pending_cmds[$];
    t_result expected_results[$];

    // Predicted block state
    lgsu_pkg::t_word life_grid [lgsu_pkg::GRID_ROWS];
    lgsu_pkg::t_word snap_mem  [lgsu_pkg::HISTORY_DEPTH][lgsu_pkg::GRID_ROWS];
    logic            snap_marked [lgsu_pkg::HISTORY_DEPTH];
    int              ring_slot;

    int accepted_count = 0;
    int results_seen   = 0;
    int error_count    = 0;
    int cycle_count    = 0;
    int step_count     = 0;
    int undo_hits      = 0;
    int undo_misses    = 0;
    int read_count     = 0;
    int toggle_count   = 0;

    logic hold_active = 1'b0;
    logic hold_used   = 1'b0;
    int   hold_cycles = 0;
    logic steady;

    assign steady = (accepted_count >= 220) && (accepted_count < 320);

    life_grid_step_with_undo_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_opcode    (i_opcode),
        .i_row_index (i_row_index),
        .i_col_index (i_col_index),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_row_bits  (o_row_bits),
        .o_status    (o_status)
    );

    always #1 i_clk = ~i_clk;

    task automatic report_mismatch(input string what);
        error_count++;
        $display("mismatch on result %0d: %s", results_seen, what);
    endtask

    function automatic logic bit_of(input lgsu_pkg::t_word w, input int c);
        if (c < 0 || c >= lgsu_pkg::GRID_COLS) begin
            return 1'b0;
        end
        return w[c];
    endfunction

    // Apply one command to the predicted state and return its result.
    task automatic predict_command(input t_cmd cmd, output t_result res);
        lgsu_pkg::t_word next_grid [lgsu_pkg::GRID_ROWS];
        lgsu_pkg::t_word up;
        lgsu_pkg::t_word mid;
        lgsu_pkg::t_word dn;
        int              n;
        res.row_bits = '0;
        res.status   = lgsu_pkg::STAT_OK;
        case (cmd.op)
            lgsu_pkg::OP_TOGGLE: begin
                toggle_count++;
                if (int'(cmd.row) < lgsu_pkg::GRID_ROWS
                    && int'(cmd.col) < lgsu_pkg::GRID_COLS) begin
                    life_grid[cmd.row][cmd.col] = ~life_grid[cmd.row][cmd.col];
                end
            end
            lgsu_pkg::OP_STEP: begin
                step_count++;
                for (int r = 0; r < lgsu_pkg::GRID_ROWS; r++) begin
                    snap_mem[ring_slot][r] = life_grid[r];
                end
                snap_marked[ring_slot] = 1'b1;
                ring_slot = (ring_slot + 1) % lgsu_pkg::HISTORY_DEPTH;
                for (int r = 0; r < lgsu_pkg::GRID_ROWS; r++) begin
                    up  = (r > 0) ? life_grid[r-1] : '0;
                    mid = life_grid[r];
                    dn  = (r < lgsu_pkg::GRID_ROWS - 1) ? life_grid[r+1] : '0;
                    next_grid[r] = '0;
                    for (int c = 0; c < lgsu_pkg::GRID_COLS; c++) begin
                        n = 0;
                        for (int dc = -1; dc <= 1; dc++) begin
                            n += bit_of(up, c + dc) + bit_of(dn, c + dc);
                            if (dc != 0) begin
                                n += bit_of(mid, c + dc);
                            end
                        end
                        next_grid[r][c] = (n == 3) || (n == 2 && mid[c]);
                    end
                end
                for (int r = 0; r < lgsu_pkg::GRID_ROWS; r++) begin
                    life_grid[r] = next_grid[r];
                end
            end
            lgsu_pkg::OP_UNDO: begin
                ring_slot = (ring_slot == 0) ? lgsu_pkg::HISTORY_DEPTH - 1 : ring_slot - 1;
                if (snap_marked[ring_slot]) begin
                    undo_hits++;
                    for (int r = 0; r < lgsu_pkg::GRID_ROWS; r++) begin
                        life_grid[r] = snap_mem[ring_slot][r];
                    end
                    snap_marked[ring_slot] = 1'b0;
                end else begin
                    undo_misses++;
                    res.status = lgsu_pkg::STAT_NO_SNAP;
                end
            end
            default: begin
                read_count++;
                if (int'(cmd.row) < lgsu_pkg::GRID_ROWS) begin
                    res.row_bits = life_grid[cmd.row] & lgsu_pkg::COL_MASK;
                end
            end
        endcase
    endtask

    function automatic void push_cmd(input logic [1:0] op, input int row, input int col);
        t_cmd cmd;
        cmd.op  = op;
        cmd.row = row[lgsu_pkg::ROW_W-1:0];
        cmd.col = col[lgsu_pkg::COL_W-1:0];
        pending_cmds.push_back(cmd);
    endfunction

    function automatic int near(input int center, input int lim);
        int v;
        v = center + int'($urandom_range(4)) - 2;
        if (v < 0) begin
            v = 0;
        end else if (v > lim - 1) begin
            v = lim - 1;
        end
        return v;
    endfunction

    // Input side: transfer, then offer the next queued command or idle.
    always @(posedge i_clk) begin : drive_proc
        t_cmd    cmd;
        t_result res;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                cmd.op  = i_opcode;
                cmd.row = i_row_index;
                cmd.col = i_col_index;
                predict_command(cmd, res);
                expected_results.push_back(res);
                accepted_count <= accepted_count + 1;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (pending_cmds.size() > 0 &&
                    (steady || $urandom_range(99) >= IDLE_PCT)) begin
                    cmd = pending_cmds.pop_front();
                    i_in_valid  <= 1'b1;
                    i_opcode    <= cmd.op;
                    i_row_index <= cmd.row;
                    i_col_index <= cmd.col;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Output side: check each transfer against the oldest prediction.
    always @(posedge i_clk) begin : watch_proc
        t_result want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result with no command pending");
                end else begin
                    want = expected_results.pop_front();
                    if (o_row_bits !== want.row_bits) begin
                        report_mismatch($sformatf("row_bits %h, want %h",
                                                  o_row_bits, want.row_bits));
                    end
                    if (o_status !== want.status) begin
                        report_mismatch($sformatf("status %b, want %b",
                                                  o_status, want.status));
                    end
                end
                results_seen <= results_seen + 1;
            end
            i_out_stall <= hold_active || (!steady && $urandom_range(99) < IDLE_PCT);
        end
    end

    // Hold the output off once for a long stretch so the block backs up.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_active <= 1'b0;
        end else if (!hold_used && results_seen >= 80) begin
            hold_active <= 1'b1;
            hold_used   <= 1'b1;
            hold_cycles <= 0;
        end else if (hold_active) begin
            hold_cycles <= hold_cycles + 1;
            if (hold_cycles == HOLD_CYCLES) begin
                hold_active <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin : stim_proc
        int kind;
        int cr;
        int cc;
        int cnt;
        int start;

        for (int r = 0; r < lgsu_pkg::GRID_ROWS; r++) begin
            life_grid[r] = '0;
        end
        for (int s = 0; s < lgsu_pkg::HISTORY_DEPTH; s++) begin
            snap_marked[s] = 1'b0;
        end
        ring_slot = 0;

        // Directed: empty grid, corners, undo with and without snapshot,
        // border blinker, block against the right edge.
        push_cmd(lgsu_pkg::OP_READ, 0, 0);
        push_cmd(lgsu_pkg::OP_TOGGLE, 0, 0);
        push_cmd(lgsu_pkg::OP_TOGGLE, 0, lgsu_pkg::GRID_COLS - 1);
        push_cmd(lgsu_pkg::OP_TOGGLE, lgsu_pkg::GRID_ROWS - 1, 0);
        push_cmd(lgsu_pkg::OP_TOGGLE, lgsu_pkg::GRID_ROWS - 1, lgsu_pkg::GRID_COLS - 1);
        push_cmd(lgsu_pkg::OP_UNDO, 0, 0);
        push_cmd(lgsu_pkg::OP_STEP, 0, 0);
        push_cmd(lgsu_pkg::OP_READ, 0, 0);
        push_cmd(lgsu_pkg::OP_READ, lgsu_pkg::GRID_ROWS - 1, 0);
        push_cmd(lgsu_pkg::OP_UNDO, 0, 0);
        push_cmd(lgsu_pkg::OP_READ, 0, 0);
        push_cmd(lgsu_pkg::OP_TOGGLE, 0, 30);
        push_cmd(lgsu_pkg::OP_TOGGLE, 0, 31);
        push_cmd(lgsu_pkg::OP_TOGGLE, 0, 32);
        push_cmd(lgsu_pkg::OP_STEP, 0, 0);
        push_cmd(lgsu_pkg::OP_READ, 0, 0);
        push_cmd(lgsu_pkg::OP_READ, 1, 0);
        push_cmd(lgsu_pkg::OP_TOGGLE, 10, 62);
        push_cmd(lgsu_pkg::OP_TOGGLE, 10, 63);
        push_cmd(lgsu_pkg::OP_TOGGLE, 11, 62);
        push_cmd(lgsu_pkg::OP_TOGGLE, 11, 63);
        push_cmd(lgsu_pkg::OP_STEP, 0, 0);
        push_cmd(lgsu_pkg::OP_READ, 10, 63);
        push_cmd(lgsu_pkg::OP_READ, 11, 0);

        start = pending_cmds.size();
        cr = 32;
        cc = 32;
        while (pending_cmds.size() - start < RANDOM_ITEMS) begin
            kind = $urandom_range(99);
            if (kind < 35) begin
                // seed a cluster, sometimes against a border
                if ($urandom_range(3) == 0) begin
                    cr = ($urandom_range(1) == 1)
                       ? lgsu_pkg::GRID_ROWS - 1 - $urandom_range(1)
                       : $urandom_range(1);
                    cc = ($urandom_range(1) == 1)
                       ? lgsu_pkg::GRID_COLS - 1 - $urandom_range(1)
                       : $urandom_range(1);
                end else begin
                    cr = $urandom_range(lgsu_pkg::GRID_ROWS - 1);
                    cc = $urandom_range(lgsu_pkg::GRID_COLS - 1);
                end
                cnt = $urandom_range(16, 5);
                for (int k = 0; k < cnt; k++) begin
                    push_cmd(lgsu_pkg::OP_TOGGLE, near(cr, lgsu_pkg::GRID_ROWS),
                             near(cc, lgsu_pkg::GRID_COLS));
                end
                push_cmd(lgsu_pkg::OP_READ, near(cr, lgsu_pkg::GRID_ROWS),
                         $urandom_range(63));
            end else if (kind < 65) begin
                cnt = $urandom_range(6, 1);
                for (int k = 0; k < cnt; k++) begin
                    push_cmd(lgsu_pkg::OP_STEP, $urandom_range(63), $urandom_range(63));
                    push_cmd(lgsu_pkg::OP_READ, near(cr, lgsu_pkg::GRID_ROWS),
                             $urandom_range(63));
                end
            end else if (kind < 85) begin
                // rewind, often past the depth of the ring
                cnt = $urandom_range(6, 1);
                for (int k = 0; k < cnt; k++) begin
                    push_cmd(lgsu_pkg::OP_UNDO, $urandom_range(63), $urandom_range(63));
                    if ($urandom_range(1) == 1) begin
                        push_cmd(lgsu_pkg::OP_READ, near(cr, lgsu_pkg::GRID_ROWS),
                                 $urandom_range(63));
                    end
                end
            end else begin
                cnt = $urandom_range(8, 1);
                for (int k = 0; k < cnt; k++) begin
                    push_cmd(2'($urandom_range(3)), $urandom_range(63), $urandom_range(63));
                end
            end
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_cmds.size() != 0 || i_in_valid) begin
            @(posedge i_clk);
        end
        while (expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d commands: %0d toggles, %0d steps, %0d reads, %0d undos restored",
                 accepted_count, toggle_count, step_count, read_count, undo_hits);
        $display("%0d undos found no snapshot; %0d results checked, %0d mismatches",
                 undo_misses, results_seen, error_count);
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
